// File: design/pcic_pkg.sv
`default_nettype none

package pcic_pkg;

    localparam int CFG_INDEX_W = 1;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_DIRECTION   = 1'd0;
    localparam cfg_index_t CFG_SIGNED_MODE = 1'd1;

    localparam int MAG_W  = 15;
    localparam int CLS_W  = 4;
    localparam int WORD_W = 21;
    localparam int LEN_W  = 5;
    localparam int DVAL_W = 16;

    // class prefix codes, right-aligned, and their lengths
    localparam logic [5:0] PREFIX_CODE [0:15] = '{
        6'd0,  6'd2,  6'd3,  6'd8,  6'd9,  6'd10, 6'd11, 6'd24,
        6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd62, 6'd63
    };
    localparam logic [2:0] PREFIX_LEN [0:15] = '{
        3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6
    };

    typedef enum logic [2:0] {
        PH_START,
        PH_HEAD,
        PH_ONE,
        PH_MID,
        PH_HIGH,
        PH_TOP,
        PH_SUFFIX
    } phase_t;

    typedef struct packed {
        logic signed [16:0] value;
        logic               code_bit;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0]        code_word;
        logic [LEN_W-1:0]         code_length;
        logic signed [DVAL_W-1:0] decoded_value;
        logic                     value_done;
        logic                     range_error;
    } result_t;

    // classified request between front and back
    typedef struct packed {
        logic             decode;
        logic             signed_mode;
        logic             range_error;
        logic             sign;
        logic [MAG_W-1:0] magnitude;
        logic [CLS_W-1:0] word_class;
        logic             code_bit;
    } work_t;

endpackage

`default_nettype wire

// File: design/pcic_fifo.sv
`default_nettype none

module pcic_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: design/pcic_front.sv
`default_nettype none

module pcic_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire pcic_pkg::cfg_index_t cfg_index,
    input  wire logic                cfg_data,
    input  wire pcic_pkg::item_t     item,
    output pcic_pkg::work_t          work
);

    import pcic_pkg::*;

    logic        direction_reg, direction_next;
    logic        signed_mode_reg, signed_mode_next;
    logic        neg;
    logic [15:0] mag_full;
    logic [CLS_W-1:0] cls;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        direction_next   = direction_reg;
        signed_mode_next = signed_mode_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DIRECTION:   direction_next   = cfg_data;
                CFG_SIGNED_MODE: signed_mode_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= 1'b0;
            signed_mode_reg <= 1'b0;
        end
        else
        begin
            direction_reg   <= direction_next;
            signed_mode_reg <= signed_mode_next;
        end
    end

    // negative values map to -v-1, which is the bitwise inverse
    assign neg      = item.value[16];
    assign mag_full = neg ? ~item.value[15:0] : item.value[15:0];

    always_comb
    begin
        cls = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (mag_full[i])
            begin
                cls = CLS_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        work.decode      = direction_reg;
        work.signed_mode = signed_mode_reg;
        work.range_error = neg ? (!signed_mode_reg || mag_full[15]) : mag_full[15];
        work.sign        = neg && signed_mode_reg;
        work.magnitude   = mag_full[MAG_W-1:0];
        work.word_class  = cls;
        work.code_bit    = item.code_bit;
    end

endmodule

`default_nettype wire

// File: design/pcic_back.sv
`default_nettype none

module pcic_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pcic_pkg::work_t work,
    input  wire logic            work_empty,
    output logic                 work_pop,
    input  wire logic            out_full,
    output logic                 out_push,
    output pcic_pkg::result_t    out_data
);

    import pcic_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [1:0]       pbits_reg, pbits_next;
    logic [1:0]       pcnt_reg, pcnt_next;
    logic [3:0]       rem_reg, rem_next;
    logic [MAG_W-1:0] acc_reg, acc_next;
    logic             sign_reg, sign_next;

    logic             dec_fire;
    logic             b;
    logic [2:0]       nb;
    logic [1:0]       ncnt;
    logic [MAG_W-1:0] acc_shift;
    logic [3:0]       rem_dec;
    logic             finish;
    logic [MAG_W-1:0] finish_mag;

    logic [3:0]        suf_n;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] enc_word;
    logic [LEN_W-1:0]  enc_len;
    logic [DVAL_W-1:0] m16;

    assign work_pop  = !work_empty && !out_full;
    assign dec_fire  = work_pop && work.decode;
    assign b         = work.code_bit;
    assign nb        = {pbits_reg, b};
    assign ncnt      = pcnt_reg + 2'd1;
    assign acc_shift = {acc_reg[MAG_W-2:0], b};
    assign rem_dec   = rem_reg - 4'd1;

    // decoder next state
    always_comb
    begin
        phase_next = phase_reg;
        pbits_next = pbits_reg;
        pcnt_next  = pcnt_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        sign_next  = sign_reg;
        if (dec_fire)
        begin
            case (phase_reg)
                PH_HEAD:
                begin
                    pbits_next = nb[1:0];
                    pcnt_next  = ncnt;
                    if (ncnt == 2'd2)
                    begin
                        pbits_next = '0;
                        pcnt_next  = '0;
                        case (nb[1:0])
                            2'b00:   phase_next = PH_START;
                            2'b01:   phase_next = PH_ONE;
                            2'b10:   phase_next = PH_MID;
                            default: phase_next = PH_HIGH;
                        endcase
                    end
                end
                PH_ONE:
                begin
                    if (b)
                    begin
                        phase_next = PH_SUFFIX;
                        rem_next   = 4'd1;
                        acc_next   = MAG_W'(1);
                    end
                    else
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_MID:
                begin
                    pbits_next = nb[1:0];
                    pcnt_next  = ncnt;
                    if (ncnt == 2'd2)
                    begin
                        phase_next = PH_SUFFIX;
                        rem_next   = 4'd2 + {2'b00, nb[1:0]};
                        acc_next   = MAG_W'(1);
                        pbits_next = '0;
                        pcnt_next  = '0;
                    end
                end
                PH_HIGH:
                begin
                    pbits_next = nb[1:0];
                    pcnt_next  = ncnt;
                    if (ncnt == 2'd3)
                    begin
                        pbits_next = '0;
                        pcnt_next  = '0;
                        if (nb != 3'd7)
                        begin
                            phase_next = PH_SUFFIX;
                            rem_next   = 4'd6 + {1'b0, nb};
                            acc_next   = MAG_W'(1);
                        end
                        else
                        begin
                            phase_next = PH_TOP;
                        end
                    end
                end
                PH_TOP:
                begin
                    phase_next = PH_SUFFIX;
                    rem_next   = 4'd13 + {3'b000, b};
                    acc_next   = MAG_W'(1);
                end
                PH_SUFFIX:
                begin
                    acc_next = acc_shift;
                    rem_next = rem_dec;
                    if (rem_dec == 4'd0)
                    begin
                        phase_next = PH_START;
                    end
                end
                default:
                begin
                    phase_next = PH_HEAD;
                    rem_next   = '0;
                    acc_next   = '0;
                    if (work.signed_mode)
                    begin
                        sign_next  = b;
                        pbits_next = '0;
                        pcnt_next  = '0;
                    end
                    else
                    begin
                        sign_next  = 1'b0;
                        pbits_next = {1'b0, b};
                        pcnt_next  = 2'd1;
                    end
                end
            endcase
            if (finish)
            begin
                pbits_next = '0;
                pcnt_next  = '0;
                rem_next   = '0;
                acc_next   = '0;
                sign_next  = 1'b0;
            end
        end
    end

    // decoder outputs
    always_comb
    begin
        finish     = 1'b0;
        finish_mag = '0;
        case (phase_reg)
            PH_HEAD:
            begin
                finish = (ncnt == 2'd2) && (nb[1:0] == 2'b00);
            end
            PH_ONE:
            begin
                finish     = !b;
                finish_mag = MAG_W'(1);
            end
            PH_SUFFIX:
            begin
                finish     = (rem_dec == 4'd0);
                finish_mag = acc_shift;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            pbits_reg <= '0;
            pcnt_reg  <= '0;
            rem_reg   <= '0;
            acc_reg   <= '0;
            sign_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pbits_reg <= pbits_next;
            pcnt_reg  <= pcnt_next;
            rem_reg   <= rem_next;
            acc_reg   <= acc_next;
            sign_reg  <= sign_next;
        end
    end

    // encoder: prefix, then bits below the leading one, then optional sign on top
    assign suf_n   = (work.word_class >= 4'd2) ? work.word_class - 4'd1 : 4'd0;
    assign mask    = (WORD_W'(1) << suf_n) - WORD_W'(1);
    assign m16     = {1'b0, finish_mag};

    always_comb
    begin
        enc_word = (WORD_W'(PREFIX_CODE[work.word_class]) << suf_n)
                 | (WORD_W'(work.magnitude) & mask);
        enc_len  = LEN_W'(PREFIX_LEN[work.word_class]) + LEN_W'(suf_n);
        if (work.signed_mode)
        begin
            enc_word = enc_word | (WORD_W'(work.sign) << enc_len);
            enc_len  = enc_len + LEN_W'(1);
        end
    end

    always_comb
    begin
        out_push = work_pop && (!work.decode || finish);
        out_data = '0;
        if (work.decode)
        begin
            out_data.decoded_value = sign_reg ? ~m16 : m16;
            out_data.value_done    = 1'b1;
        end
        else if (work.range_error)
        begin
            out_data.range_error = 1'b1;
        end
        else
        begin
            out_data.code_word   = enc_word;
            out_data.code_length = enc_len;
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result written into a full queue");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        work_pop |-> !work_empty)
        else $error("request taken from an empty queue");

    a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_fire && finish) |=> (phase_reg == PH_START && acc_reg == '0))
        else $error("decoder state not cleared after a value");

    a_suffix_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SUFFIX) |-> (rem_reg != 4'd0))
        else $error("suffix phase with no bits left");

endmodule

`default_nettype wire

// File: design/prefix_class_integer_codec_top.sv
// A request passes through the work queue, then the result queue, to the result ports.
// Throughput: one request per cycle while the result queue has room, set by the
// single-pass encoder and the one-bit-per-cycle decoder state machine; QUEUE_DEPTH
// entries buffer each side. Decode requests that do not end a code word produce no
// result. Reset (rst_n, asynchronous, active low) clears both queues, the registers
// and the decoder to waiting for a sign or prefix bit.
`default_nettype none

module prefix_class_integer_codec_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire pcic_pkg::item_t      item,
    output logic                      empty,
    input  wire logic                 pop,
    output pcic_pkg::result_t         result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire pcic_pkg::cfg_index_t cfg_index,
    input  wire logic                 cfg_data
);

    import pcic_pkg::*;

    work_t   work_in;
    work_t   work_out;
    logic    work_empty;
    logic    work_pop;
    logic    out_full;
    logic    out_push;
    result_t out_data;

    pcic_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .work      (work_in)
    );

    pcic_fifo #(
        .WIDTH ($bits(work_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (work_in),
        .full  (full),
        .pop   (work_pop),
        .rdata (work_out),
        .empty (work_empty)
    );

    pcic_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work       (work_out),
        .work_empty (work_empty),
        .work_pop   (work_pop),
        .out_full   (out_full),
        .out_push   (out_push),
        .out_data   (out_data)
    );

    pcic_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_data),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire
